[hdl/nv12q_pkg.sv]
// Shared types and constants of the NV12 quad to RGB converter.
package nv12q_pkg;

    // Field widths fixed by the interface.
    localparam int CFG_WIDTH   = 13;
    localparam int COORD_WIDTH = 12;
    localparam int PIX_WIDTH   = 8;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd1280;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd720;

    // Pixel index of the bottom-right pixel, the last one of a quad.
    localparam logic [1:0] PIX_LAST = 2'd3;

    // BT.601 studio-range coefficients and offsets.
    localparam logic signed [19:0] COEF_Y    = 20'sd298;
    localparam logic signed [19:0] COEF_R_CR = 20'sd408;
    localparam logic signed [19:0] COEF_G_CB = 20'sd100;
    localparam logic signed [19:0] COEF_G_CR = 20'sd208;
    localparam logic signed [19:0] COEF_B_CB = 20'sd516;
    localparam logic signed [19:0] LUMA_OFFSET   = 20'sd16;
    localparam logic signed [19:0] CHROMA_OFFSET = 20'sd128;
    localparam logic [PIX_WIDTH-1:0] CHANNEL_MAX = 8'd255;

    // Position of the quad in the frame, captured when it is accepted.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] base_x;
        logic [COORD_WIDTH-1:0] base_y;
        logic                   frame_end;
    } quad_pos_t;

endpackage

[hdl/nv12q_to_rgb_converter_unit.sv]
// Top level of the NV12 quad to RGB converter.
//
// Input channel: one transfer carries a 2x2 quad of an NV12 frame, four luma
// samples and the shared Cb/Cr pair. Output channel: one transfer carries one
// RGB pixel with its coordinates and the quad and frame end flags; a quad
// gives four pixels in the order top-left, top-right, bottom-left,
// bottom-right.
// A quad is held in the quad register and its pixels are converted one at a
// time into the output register. The first pixel goes from the quad register
// into the output register; the other three follow one per cycle while the
// receiver takes them. The output port, one pixel per cycle, sets the sustained
// rate. The next quad is taken in the same cycle that the last pixel of the
// current quad moves into the output register, so there is no gap between
// quads.
// When the receiver stalls, the output register holds its pixel and the quad
// register holds its place; once the quad register is full the input
// channel stalls as well. Reset clears all valid flags and the quad counters
// and restores the frame size to 1280 by 720. The user must make frame size
// writes only while the block is idle; the block itself does not enforce this.
module nv12_quad_to_rgb_converter_unit
    import nv12q_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_enable,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_WIDTH-1:0]   luma_top_left,
    input  logic [PIX_WIDTH-1:0]   luma_top_right,
    input  logic [PIX_WIDTH-1:0]   luma_bottom_left,
    input  logic [PIX_WIDTH-1:0]   luma_bottom_right,
    input  logic [PIX_WIDTH-1:0]   chroma_blue,
    input  logic [PIX_WIDTH-1:0]   chroma_red,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_WIDTH-1:0]   red,
    output logic [PIX_WIDTH-1:0]   green,
    output logic [PIX_WIDTH-1:0]   blue,
    output logic [COORD_WIDTH-1:0] pixel_x,
    output logic [COORD_WIDTH-1:0] pixel_y,
    output logic                   last_of_quad,
    output logic                   end_of_frame
);

    // Handshake and sequencing.
    logic in_transfer;
    logic advance;
    logic load;
    logic quad_done;

    // Quad register: valid while pixels of the quad remain to be converted.
    logic                 quad_valid_reg;
    logic                 quad_valid_next;
    logic [1:0]           pix_idx_reg;
    logic [1:0]           pix_idx_next;
    logic [PIX_WIDTH-1:0] luma_reg [4];
    logic [PIX_WIDTH-1:0] cb_reg;
    logic [PIX_WIDTH-1:0] cr_reg;
    quad_pos_t            pos_reg;
    quad_pos_t            pos_now;

    // Current pixel.
    logic [PIX_WIDTH-1:0] luma_sel;
    logic [PIX_WIDTH-1:0] red_conv;
    logic [PIX_WIDTH-1:0] green_conv;
    logic [PIX_WIDTH-1:0] blue_conv;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PIX_WIDTH-1:0]   red_reg;
    logic [PIX_WIDTH-1:0]   green_reg;
    logic [PIX_WIDTH-1:0]   blue_reg;
    logic [COORD_WIDTH-1:0] pixel_x_reg;
    logic [COORD_WIDTH-1:0] pixel_y_reg;
    logic                   last_of_quad_reg;
    logic                   end_of_frame_reg;

    // The output register moves on when it is empty or its pixel leaves.
    assign advance     = !out_valid_reg || !out_stall;
    assign load        = advance && quad_valid_reg;
    assign quad_done   = load && (pix_idx_reg == PIX_LAST);
    assign in_stall    = quad_valid_reg && !quad_done;
    assign in_transfer = in_valid && !in_stall;

    nv12q_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .advance          (in_transfer),
        .pos              (pos_now)
    );

    always_comb
    begin
        quad_valid_next = quad_valid_reg;
        pix_idx_next    = pix_idx_reg;
        if (in_transfer)
        begin
            quad_valid_next = 1'b1;
            pix_idx_next    = '0;
        end
        else if (load)
        begin
            quad_valid_next = !quad_done;
            pix_idx_next    = pix_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_valid_reg <= 1'b0;
            pix_idx_reg    <= '0;
        end
        else
        begin
            quad_valid_reg <= quad_valid_next;
            pix_idx_reg    <= pix_idx_next;
        end
    end

    // Quad payload is captured with the position counters as they stand
    // before this quad advances them.
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            luma_reg[0] <= luma_top_left;
            luma_reg[1] <= luma_top_right;
            luma_reg[2] <= luma_bottom_left;
            luma_reg[3] <= luma_bottom_right;
            cb_reg      <= chroma_blue;
            cr_reg      <= chroma_red;
            pos_reg     <= pos_now;
        end
    end

    assign luma_sel = luma_reg[pix_idx_reg];

    nv12q_convert u_convert (
        .luma  (luma_sel),
        .cb    (cb_reg),
        .cr    (cr_reg),
        .red   (red_conv),
        .green (green_conv),
        .blue  (blue_conv)
    );

    assign out_valid_next = advance ? quad_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The quad's base coordinates are even, so the pixel's offset within the
    // quad is simply ORed into the lowest bit.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg          <= red_conv;
            green_reg        <= green_conv;
            blue_reg         <= blue_conv;
            pixel_x_reg      <= pos_reg.base_x | COORD_WIDTH'(pix_idx_reg[0]);
            pixel_y_reg      <= pos_reg.base_y | COORD_WIDTH'(pix_idx_reg[1]);
            last_of_quad_reg <= (pix_idx_reg == PIX_LAST);
            end_of_frame_reg <= (pix_idx_reg == PIX_LAST) && pos_reg.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign last_of_quad = last_of_quad_reg;
    assign end_of_frame = end_of_frame_reg;

`ifndef NO_ASSERTIONS
    // The frame end flag only ever marks the last pixel of a quad.
    a_eof_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!end_of_frame || last_of_quad))
        else $error("end_of_frame without last_of_quad");

    // The last pixel of a quad is its bottom-right pixel.
    a_last_is_bottom_right: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_quad) |-> (pixel_x[0] && pixel_y[0]))
        else $error("last pixel of quad is not bottom-right");

    // Once a pixel other than the last leaves, the next pixel of the quad
    // follows straight away.
    a_quad_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_quad) |=> out_valid)
        else $error("gap inside a quad");

    // A newly taken quad starts at its top-left pixel.
    a_new_quad_index: assert property (@(posedge clk) disable iff (!rst_n)
        in_transfer |=> (quad_valid_reg && pix_idx_reg == 2'd0))
        else $error("new quad does not start at first pixel");

    // With no quad held, the input side is never stalled.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !quad_valid_reg |-> !in_stall)
        else $error("input stalled while quad register empty");
`endif

endmodule

[hdl/nv12q_position.sv]
// Frame size registers and quad column/row counters.
module nv12q_position
    import nv12q_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 advance,
    output quad_pos_t            pos
);

    localparam int CW = $clog2(MAX_DIMENSION / 2 + 1);
    localparam logic [13:0] MAX_EVEN = 14'((MAX_DIMENSION / 2) * 2);

    logic [CFG_WIDTH-1:0] frame_width_reg;
    logic [CFG_WIDTH-1:0] frame_height_reg;
    logic [CW-1:0]        quad_column_reg;
    logic [CW-1:0]        quad_column_next;
    logic [CW-1:0]        quad_row_reg;
    logic [CW-1:0]        quad_row_next;
    logic [13:0]          quads_per_row;
    logic [13:0]          quad_rows;
    logic                 row_end;
    logic                 last_row;
    logic [CW:0]          col_doubled;
    logic [CW:0]          row_doubled;

    // Dimension rounded down to even and held within 2..MAX_DIMENSION.
    function automatic logic [13:0] effective_dim(input logic [CFG_WIDTH-1:0] v);
        logic [13:0] d;
        d = {1'b0, v[CFG_WIDTH-1:1], 1'b0};
        if (d < 14'd2)
        begin
            d = 14'd2;
        end
        if (d > MAX_EVEN)
        begin
            d = MAX_EVEN;
        end
        return d;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        quads_per_row = effective_dim(frame_width_reg) >> 1;
        quad_rows     = effective_dim(frame_height_reg) >> 1;
        row_end  = (14'(quad_column_reg) + 14'd1) >= quads_per_row;
        last_row = (14'(quad_row_reg) + 14'd1) >= quad_rows;

        quad_column_next = quad_column_reg;
        quad_row_next    = quad_row_reg;
        if (advance)
        begin
            if (row_end)
            begin
                quad_column_next = '0;
                quad_row_next    = last_row ? '0 : quad_row_reg + 1'b1;
            end
            else
            begin
                quad_column_next = quad_column_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_column_reg <= '0;
            quad_row_reg    <= '0;
        end
        else
        begin
            quad_column_reg <= quad_column_next;
            quad_row_reg    <= quad_row_next;
        end
    end

    // Pixel coordinates of the quad's top-left corner, kept to 12 bits.
    assign col_doubled    = {quad_column_reg, 1'b0};
    assign row_doubled    = {quad_row_reg, 1'b0};
    assign pos.base_x     = COORD_WIDTH'(col_doubled);
    assign pos.base_y     = COORD_WIDTH'(row_doubled);
    assign pos.frame_end  = row_end && last_row;

endmodule

[hdl/nv12q_convert.sv]
// Conversion of one luma sample and a chroma pair to clamped RGB.
module nv12q_convert
    import nv12q_pkg::*;
(
    input  logic [PIX_WIDTH-1:0] luma,
    input  logic [PIX_WIDTH-1:0] cb,
    input  logic [PIX_WIDTH-1:0] cr,
    output logic [PIX_WIDTH-1:0] red,
    output logic [PIX_WIDTH-1:0] green,
    output logic [PIX_WIDTH-1:0] blue
);

    logic signed [19:0] ey;
    logic signed [19:0] eb;
    logic signed [19:0] er;
    logic signed [19:0] red_sum;
    logic signed [19:0] green_sum;
    logic signed [19:0] blue_sum;

    // A negative sum truncates to zero or below, so it clamps to zero;
    // otherwise the quotient is a plain shift, clamped at the top.
    function automatic logic [PIX_WIDTH-1:0] clamp_channel(input logic signed [19:0] num);
        logic [11:0] q;
        q = num[19:8];
        if (num < 0)
        begin
            return '0;
        end
        else if (q > 12'(CHANNEL_MAX))
        begin
            return CHANNEL_MAX;
        end
        else
        begin
            return q[PIX_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        ey = signed'(20'(luma)) - LUMA_OFFSET;
        eb = signed'(20'(cb)) - CHROMA_OFFSET;
        er = signed'(20'(cr)) - CHROMA_OFFSET;
        red_sum   = COEF_Y * ey + COEF_R_CR * er;
        green_sum = COEF_Y * ey - COEF_G_CB * eb - COEF_G_CR * er;
        blue_sum  = COEF_Y * ey + COEF_B_CB * eb;
    end

    assign red   = clamp_channel(red_sum);
    assign green = clamp_channel(green_sum);
    assign blue  = clamp_channel(blue_sum);

endmodule

[verif/nv12_quad_to_rgb_converter_unit_tb.sv]
// Self-checking testbench of the NV12 quad to RGB converter.
`timescale 1ns / 1ps

module nv12_quad_to_rgb_converter_unit_tb;
    import nv12q_pkg::*;

    localparam int MAX_DIMENSION = 4096;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LONG_HOLD     = 80;
    localparam int TIMEOUT_NS    = 5_000_000;

    // Register indexes that lie beyond the register list; writes to them
    // must leave the frame size alone.
    localparam logic [1:0] SPARE_INDEX_LOW  = 2'd2;
    localparam logic [1:0] SPARE_INDEX_HIGH = 2'd3;

    // BT.601 studio-range arithmetic, kept apart from the design's package.
    localparam int LUMA_BIAS     = 16;
    localparam int CHROMA_BIAS   = 128;
    localparam int GAIN_Y        = 298;
    localparam int GAIN_RED_CR   = 408;
    localparam int GAIN_GREEN_CB = 100;
    localparam int GAIN_GREEN_CR = 208;
    localparam int GAIN_BLUE_CB  = 516;
    localparam int SCALE         = 256;
    localparam int BYTE_MAX      = 255;

    typedef struct {
        logic [PIX_WIDTH-1:0] luma [4];
        logic [PIX_WIDTH-1:0] cb;
        logic [PIX_WIDTH-1:0] cr;
    } quad_t;

    typedef struct {
        logic [PIX_WIDTH-1:0]   red;
        logic [PIX_WIDTH-1:0]   green;
        logic [PIX_WIDTH-1:0]   blue;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic                   quad_end;
        logic                   frame_end;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_enable = 1'b0;
    logic [1:0]             cfg_index = 2'd0;
    logic [CFG_WIDTH-1:0]   cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIX_WIDTH-1:0]   luma_top_left = '0;
    logic [PIX_WIDTH-1:0]   luma_top_right = '0;
    logic [PIX_WIDTH-1:0]   luma_bottom_left = '0;
    logic [PIX_WIDTH-1:0]   luma_bottom_right = '0;
    logic [PIX_WIDTH-1:0]   chroma_blue = '0;
    logic [PIX_WIDTH-1:0]   chroma_red = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIX_WIDTH-1:0]   red;
    logic [PIX_WIDTH-1:0]   green;
    logic [PIX_WIDTH-1:0]   blue;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic                   last_of_quad;
    logic                   end_of_frame;

    // Our own copy of the frame size registers and the quad position.
    logic [CFG_WIDTH-1:0] frame_width_reg  = FRAME_WIDTH_RESET;
    logic [CFG_WIDTH-1:0] frame_height_reg = FRAME_HEIGHT_RESET;
    int                   quad_col = 0;
    int                   quad_row = 0;

    // Pixels still owed by the block, oldest first.
    pixel_t expected_pixels [$];

    int  errors = 0;
    int  quads_sent = 0;
    int  pixels_checked = 0;
    int  frames_seen = 0;
    int  input_stall_cycles = 0;
    int  hold_request = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    nv12_quad_to_rgb_converter_unit #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) dut (.*);

    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case the block hangs or loses a handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // A register value of 0 or 1 behaves as 2, odd values are rounded down,
    // and anything above the largest frame is held at the largest frame.
    function automatic int usable_dimension(input logic [CFG_WIDTH-1:0] value);
        int dim;
        dim = int'(value) & ~1;
        if (dim < 2)
            dim = 2;
        if (dim > MAX_DIMENSION)
            dim = MAX_DIMENSION & ~1;
        return dim;
    endfunction

    // The scaled sum is truncated towards zero and then saturated to a byte.
    function automatic logic [PIX_WIDTH-1:0] clamp_to_byte(input int scaled_sum);
        int level;
        level = scaled_sum / SCALE;
        if (level > BYTE_MAX)
            level = BYTE_MAX;
        if (level < 0)
            level = 0;
        return PIX_WIDTH'(level);
    endfunction

    // Works out the four pixels of one accepted quad and moves the quad
    // position on. The coordinates come from the counters as they stand,
    // even when a smaller frame has just been written, and a counter at or
    // past the new limit wraps once this quad is done.
    task automatic predict_quad_pixels(input quad_t q);
        int     quads_per_row;
        int     quad_rows;
        int     ey;
        int     eb;
        int     er;
        bit     row_end;
        bit     frame_end;
        pixel_t px;
        quads_per_row = usable_dimension(frame_width_reg) / 2;
        quad_rows     = usable_dimension(frame_height_reg) / 2;
        row_end       = (quad_col + 1) >= quads_per_row;
        frame_end     = row_end && ((quad_row + 1) >= quad_rows);
        eb = int'(q.cb) - CHROMA_BIAS;
        er = int'(q.cr) - CHROMA_BIAS;
        for (int k = 0; k < 4; k++)
        begin
            ey = int'(q.luma[k]) - LUMA_BIAS;
            px.red       = clamp_to_byte(GAIN_Y * ey + GAIN_RED_CR * er);
            px.green     = clamp_to_byte(GAIN_Y * ey - GAIN_GREEN_CB * eb
                                         - GAIN_GREEN_CR * er);
            px.blue      = clamp_to_byte(GAIN_Y * ey + GAIN_BLUE_CB * eb);
            px.x         = COORD_WIDTH'(quad_col * 2 + (k % 2));
            px.y         = COORD_WIDTH'(quad_row * 2 + (k / 2));
            px.quad_end  = (k == 3);
            px.frame_end = (k == 3) && frame_end;
            expected_pixels.push_back(px);
        end
        if (row_end)
        begin
            quad_col = 0;
            quad_row = ((quad_row + 1) >= quad_rows) ? 0 : quad_row + 1;
        end
        else
        begin
            quad_col = quad_col + 1;
        end
    endtask

    function automatic quad_t make_quad(input logic [7:0] tl, input logic [7:0] tr,
                                        input logic [7:0] bl, input logic [7:0] br,
                                        input logic [7:0] cb, input logic [7:0] cr);
        quad_t q;
        q.luma[0] = tl;
        q.luma[1] = tr;
        q.luma[2] = bl;
        q.luma[3] = br;
        q.cb      = cb;
        q.cr      = cr;
        return q;
    endfunction

    // Samples lean towards the two ends of the byte so that clamping is
    // exercised often.
    function automatic logic [PIX_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return PIX_WIDTH'($urandom);
        endcase
    endfunction

    function automatic quad_t random_quad();
        return make_quad(random_sample(), random_sample(), random_sample(),
                         random_sample(), random_sample(), random_sample());
    endfunction

    // Mostly small frames so that row and frame ends come often, now and
    // then something near or beyond the largest frame.
    function automatic logic [CFG_WIDTH-1:0] random_dimension();
        case ($urandom_range(0, 9))
            0: return CFG_WIDTH'($urandom_range(0, 8191));
            1: return CFG_WIDTH'($urandom_range(4090, 4100));
            default: return CFG_WIDTH'($urandom_range(0, 12));
        endcase
    endfunction

    // One register write. The enable is lowered again after the write edge, before
    // the task returns, so that a following write never meets it in the same time step.
    task automatic write_register(input logic [1:0] index, input logic [CFG_WIDTH-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        @(posedge clk);
        if (index == CFG_FRAME_WIDTH)
            frame_width_reg = value;
        else if (index == CFG_FRAME_HEIGHT)
            frame_height_reg = value;
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_WIDTH-1:0] width, input logic [CFG_WIDTH-1:0] height);
        write_register(CFG_FRAME_WIDTH, width);
        write_register(CFG_FRAME_HEIGHT, height);
    endtask

    // Offers one quad, with an optional idle gap first, and returns at the
    // clock edge at which the transfer takes place. Valid stays high
    // afterwards so that the next quad can follow without a gap.
    task automatic send_quad(input quad_t q);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        luma_top_left     <= q.luma[0];
        luma_top_right    <= q.luma[1];
        luma_bottom_left  <= q.luma[2];
        luma_bottom_right <= q.luma[3];
        chroma_blue       <= q.cb;
        chroma_red        <= q.cr;
        do
            @(posedge clk);
        while (in_stall);
        predict_quad_pixels(q);
        quads_sent++;
    endtask

    task automatic send_random_quads(input int count);
        repeat (count) send_quad(random_quad());
    endtask

    // Called at the edge of the last transfer of a burst.
    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // Waits for every owed pixel and then lets the block settle, so that a
    // register write afterwards finds it idle.
    task automatic wait_drain();
        int waited;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time,
                     expected_pixels.size());
            errors++;
            expected_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Quads at the reset frame size of 1280 by 720: the extremes of luma
    // and chroma, neutral black and white, and mixed saturating colours.
    task automatic test_reset_defaults();
        send_quad(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_quad(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_quad(make_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128));
        send_quad(make_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
        send_quad(make_quad(8'd0, 8'd255, 8'd16, 8'd235, 8'd0, 8'd255));
        send_quad(make_quad(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
        send_quad(make_quad(8'd128, 8'd81, 8'd145, 8'd41, 8'd128, 8'd255));
        stop_sending();
        wait_drain();
    endtask

    // Frame sizes at and beyond the limits of the registers.
    task automatic test_dimension_limits();
        // Widths and heights of 0 and 1 act as 2: every quad ends a frame.
        set_frame(13'd0, 13'd1);
        send_quad(make_quad(8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32));
        send_quad(make_quad(8'd64, 8'd128, 8'd254, 8'd253, 8'd251, 8'd247));
        send_quad(make_quad(8'd239, 8'd223, 8'd191, 8'd127, 8'd170, 8'd85));
        stop_sending();
        wait_drain();
        // An odd width rounds down to two and the largest register value
        // is held at the largest frame height.
        set_frame(13'd3, 13'd8191);
        send_quad(make_quad(8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170));
        send_quad(make_quad(8'd255, 8'd16, 8'd235, 8'd0, 8'd240, 8'd16));
        send_quad(make_quad(8'd100, 8'd200, 8'd50, 8'd150, 8'd16, 8'd240));
        stop_sending();
        wait_drain();
        // Back to a closed frame, then writes to indexes beyond the list,
        // which must not disturb the 4 by 4 frame.
        set_frame(13'd5, 13'd4);
        send_random_quads(3);
        stop_sending();
        wait_drain();
        write_register(SPARE_INDEX_LOW, 13'd0);
        write_register(SPARE_INDEX_HIGH, 13'h1FFF);
        send_random_quads(5);
        stop_sending();
        wait_drain();
        set_frame(13'd4097, 13'd4098);
        send_random_quads(3);
        stop_sending();
        wait_drain();
    endtask

    // The frame shrinks while the quad counters stand well inside the old
    // frame: the next quad keeps the old coordinates and the counter wraps.
    task automatic test_mid_frame_resize();
        set_frame(13'd4096, 13'd4096);
        send_random_quads(24);
        stop_sending();
        wait_drain();
        write_register(CFG_FRAME_WIDTH, 13'd8);
        send_random_quads(6);
        stop_sending();
        wait_drain();
        set_frame(13'd4, 13'd40);
        send_random_quads(30);
        stop_sending();
        wait_drain();
        write_register(CFG_FRAME_HEIGHT, 13'd6);
        send_random_quads(8);
        stop_sending();
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while quads keep coming,
    // so the block fills up and stalls its input.
    task automatic test_backpressure();
        set_frame(13'd6, 13'd6);
        sender_idles = 1'b0;
        hold_request = LONG_HOLD;
        send_random_quads(16);
        stop_sending();
        wait_drain();
        sender_idles = 1'b1;
    endtask

    // Phases of random frame sizes and random content, with idling on
    // either side switched on or off per phase.
    task automatic test_random_frames();
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            set_frame(random_dimension(), random_dimension());
            send_random_quads($urandom_range(10, 20));
            stop_sending();
            wait_drain();
        end
    endtask

    // The last part runs with no idling on either side, at full rate.
    task automatic test_full_rate();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        set_frame(13'd6, 13'd4);
        send_random_quads(30);
        stop_sending();
        wait_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_dimension_limits();
        test_mid_frame_resize();
        test_backpressure();
        test_random_frames();
        test_full_rate();
        wait_drain();
        $display("Covered %0d quads and %0d pixels across %0d frame ends,",
                 quads_sent, pixels_checked, frames_seen);
        $display("with %0d cycles of input backpressure and %0d errors.",
                 input_stall_cycles, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver pacing: either a long hold asked for by a test, or short
    // random bursts of stall while idling is allowed.
    initial
    begin : receiver_pacing
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                out_stall <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Every pixel transfer is compared with the oldest owed pixel. Values
    // are sampled at the edge, before the block updates its outputs.
    always @(posedge clk)
    begin : pixel_checker
        pixel_t want;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel transfer at x %0d, y %0d",
                             $time, pixel_x, pixel_y);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("last_of_quad", want.quad_end, last_of_quad);
                    check_field("end_of_frame", want.frame_end, end_of_frame);
                    pixels_checked++;
                    if (end_of_frame)
                        frames_seen++;
                end
            end
        end
    end

endmodule

[sim.f]
hdl/nv12q_pkg.sv
hdl/nv12q_position.sv
hdl/nv12q_convert.sv
hdl/nv12q_to_rgb_converter_unit.sv
verif/nv12_quad_to_rgb_converter_unit_tb.sv
